/* hdl/brb_pkg.sv */
// Package for the byte ring buffer with rewind history.
// Holds the sizes, command and status codes, controller states and the
// command/status structs shared by the controller and the datapath.
package brb_pkg;

	localparam int BUFFER_BYTES    = 4096;
	localparam int RESERVE_DIVISOR = 16;

	localparam int ADDR_W    = $clog2(BUFFER_BYTES);
	localparam int COUNT_W   = ADDR_W + 1;
	localparam int POS_W     = 64;
	localparam int OUT_POS_W = 63;
	localparam int RESERVE_W = 12;
	localparam int CMD_W     = 3;
	localparam int STATUS_W  = 2;
	localparam int BYTE_W    = 8;

	localparam logic [COUNT_W-1:0]   BUF_COUNT     = COUNT_W'(BUFFER_BYTES);
	localparam logic [RESERVE_W-1:0] RESERVE_RESET = RESERVE_W'(BUFFER_BYTES / RESERVE_DIVISOR);

	localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SEEK_REL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SEEK_ABS = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_OUT_RANGE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_CHECK,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic calc;
		logic check;
		logic apply;
		logic load_out;
	} brb_cmd_t;

	typedef struct packed {
		logic out_free;
	} brb_stat_t;

endpackage

/* hdl/brb_ctrl.sv */
// Controller state machine of the byte ring buffer.
// Steps each request through calc, check, apply and result hand-off.
// Depends on brb_pkg.
module brb_ctrl
	import brb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      cfg_ready,
	input  brb_stat_t stat,
	output brb_cmd_t  cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_CALC;
				end
			end
			ST_CALC:  state_next = ST_CHECK;
			ST_CHECK: state_next = ST_APPLY;
			ST_APPLY: state_next = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_stall     = 1'b1;
		cfg_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cfg_ready   = 1'b1;
				cmd.capture = in_valid;
			end
			ST_CALC:  cmd.calc  = 1'b1;
			ST_CHECK: cmd.check = 1'b1;
			ST_APPLY: cmd.apply = 1'b1;
			ST_DONE:  cmd.load_out = stat.out_free;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

/* hdl/brb_datapath.sv */
// Datapath of the byte ring buffer: byte store, pointers, counters,
// stream position, range checks and the result register.
// Depends on brb_pkg.
module brb_datapath
	import brb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  brb_cmd_t              cmd,
	output brb_stat_t             stat,
	input  logic [CMD_W-1:0]      cmd_in,
	input  logic [BYTE_W-1:0]     write_byte,
	input  logic [POS_W-1:0]      seek_offset,
	input  logic                  cfg_we,
	input  logic [RESERVE_W-1:0]  min_reserve,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [BYTE_W-1:0]     read_byte,
	output logic [OUT_POS_W-1:0]  stream_position,
	output logic [COUNT_W-1:0]    unread_count,
	output logic [COUNT_W-1:0]    history_count
);

	logic [BYTE_W-1:0] mem [BUFFER_BYTES];

	logic [CMD_W-1:0]     cmd_q;
	logic [BYTE_W-1:0]    wbyte_q;
	logic [POS_W-1:0]     off_q;
	logic [POS_W-1:0]     d_q;
	logic [POS_W-1:0]     lo_q;
	logic [POS_W-1:0]     hi_q;
	logic [POS_W-1:0]     nhist_q;
	logic                 ok_q;
	logic [STATUS_W-1:0]  stat_code_q;
	logic [BYTE_W-1:0]    rdata_q;

	logic [ADDR_W-1:0]    rp_q;
	logic [ADDR_W-1:0]    wp_q;
	logic [COUNT_W-1:0]   unread_q;
	logic [COUNT_W-1:0]   hist_q;
	logic [COUNT_W-1:0]   nw_q;
	logic [POS_W-1:0]     pos_q;
	logic [RESERVE_W-1:0] reserve_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [BYTE_W-1:0]    out_rbyte_q;
	logic [OUT_POS_W-1:0] out_pos_q;
	logic [COUNT_W-1:0]   out_unread_q;
	logic [COUNT_W-1:0]   out_hist_q;

	logic take_write;
	logic rel_ok;
	logic abs_ok;
	logic check_ok;
	logic read_hit;

	assign stat.out_free = !out_valid_q || !out_stall;

	assign take_write = (unread_q == '0) ||
		((unread_q < BUF_COUNT) && ((BUF_COUNT - unread_q) > {1'b0, reserve_q}));
	assign rel_ok = d_q[POS_W-1] ? ($signed(d_q) >= $signed(nhist_q))
		: (d_q <= POS_W'(unread_q));
	assign abs_ok = !off_q[POS_W-1] && (off_q >= lo_q) && (off_q <= hi_q);
	assign read_hit = (cmd_q == CMD_READ) && ok_q;

	always_comb begin
		unique case (cmd_q)
			CMD_WRITE:    check_ok = take_write;
			CMD_READ:     check_ok = (unread_q != '0);
			CMD_SEEK_REL: check_ok = rel_ok;
			CMD_SEEK_ABS: check_ok = abs_ok;
			CMD_FLUSH:    check_ok = 1'b1;
			default:      check_ok = 1'b0;
		endcase
	end

	// Request capture, range arithmetic and the range verdict.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= cmd_in;
			wbyte_q <= write_byte;
			off_q   <= seek_offset;
		end
		if (cmd.calc) begin
			d_q     <= (cmd_q == CMD_SEEK_ABS) ? (off_q - pos_q) : off_q;
			lo_q    <= pos_q - POS_W'(hist_q);
			hi_q    <= pos_q + POS_W'(unread_q);
			nhist_q <= POS_W'(0) - POS_W'(hist_q);
		end
		if (cmd.check) begin
			ok_q <= check_ok;
			if (check_ok) begin
				stat_code_q <= STAT_OK;
			end else begin
				unique case (cmd_q)
					CMD_WRITE: stat_code_q <= STAT_FULL;
					CMD_READ:  stat_code_q <= STAT_EMPTY;
					default:   stat_code_q <= STAT_OUT_RANGE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && ok_q && (cmd_q == CMD_WRITE)) begin
			mem[wp_q] <= wbyte_q;
		end
		if (cmd.apply && ok_q && (cmd_q == CMD_READ)) begin
			rdata_q <= mem[rp_q];
		end
	end

	// A seek moves the read pointer by the offset modulo the buffer size,
	// and the counters by the offset modulo twice the buffer size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			wp_q      <= '0;
			unread_q  <= '0;
			hist_q    <= '0;
			nw_q      <= BUF_COUNT;
			pos_q     <= '0;
			reserve_q <= RESERVE_RESET;
		end else begin
			if (cfg_we) begin
				reserve_q <= min_reserve;
			end
			if (cmd.apply && ok_q) begin
				unique case (cmd_q)
					CMD_WRITE: begin
						wp_q     <= wp_q + 1'b1;
						unread_q <= unread_q + 1'b1;
						if (nw_q != '0) begin
							nw_q <= nw_q - 1'b1;
						end else if (hist_q != '0) begin
							hist_q <= hist_q - 1'b1;
						end
					end
					CMD_READ: begin
						rp_q     <= rp_q + 1'b1;
						unread_q <= unread_q - 1'b1;
						hist_q   <= hist_q + 1'b1;
						pos_q    <= pos_q + 1'b1;
					end
					CMD_SEEK_REL, CMD_SEEK_ABS: begin
						rp_q     <= rp_q + d_q[ADDR_W-1:0];
						unread_q <= unread_q - d_q[COUNT_W-1:0];
						hist_q   <= hist_q + d_q[COUNT_W-1:0];
						pos_q    <= pos_q + d_q;
					end
					CMD_FLUSH: begin
						rp_q     <= '0;
						wp_q     <= '0;
						unread_q <= '0;
						hist_q   <= '0;
						nw_q     <= BUF_COUNT;
						pos_q    <= '0;
					end
					default: begin
						pos_q <= pos_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= stat_code_q;
			out_rbyte_q  <= read_hit ? rdata_q : '0;
			out_pos_q    <= pos_q[OUT_POS_W-1:0];
			out_unread_q <= unread_q;
			out_hist_q   <= hist_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign read_byte       = out_rbyte_q;
	assign stream_position = out_pos_q;
	assign unread_count    = out_unread_q;
	assign history_count   = out_hist_q;

endmodule

/* hdl/byte_ring_buffer_with_rewind.sv */
// Byte ring buffer with rewind history: top level joining controller and datapath.
// Flow: a request is captured, then passes the calc, check and apply states,
// and its result is registered in the done state once the output is free; a new
// request is taken only in idle, even while an earlier result waits for its receiver.
// Reset: counters, pointers and position clear, min_reserve returns to 256,
// the byte store keeps its contents and needs no clearing pass.
module byte_ring_buffer_with_rewind
	import brb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [BYTE_W-1:0]     write_byte,
	input  logic [POS_W-1:0]      seek_offset,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [RESERVE_W-1:0]  min_reserve,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [BYTE_W-1:0]     read_byte,
	output logic [OUT_POS_W-1:0]  stream_position,
	output logic [COUNT_W-1:0]    unread_count,
	output logic [COUNT_W-1:0]    history_count
);

	brb_cmd_t  ctrl_cmd;
	brb_stat_t dp_stat;

	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd)
	);

	brb_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (ctrl_cmd),
		.stat            (dp_stat),
		.cmd_in          (cmd),
		.write_byte      (write_byte),
		.seek_offset     (seek_offset),
		.cfg_we          (cfg_valid && cfg_ready),
		.min_reserve     (min_reserve),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.read_byte       (read_byte),
		.stream_position (stream_position),
		.unread_count    (unread_count),
		.history_count   (history_count)
	);

endmodule

/* hdl/brb_checker.sv */
// Port-level checks for the byte ring buffer, bound to the top level.
// Depends on brb_pkg and byte_ring_buffer_with_rewind.
module brb_checker
	import brb_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [CMD_W-1:0]      cmd,
	input logic [BYTE_W-1:0]     write_byte,
	input logic [POS_W-1:0]      seek_offset,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [RESERVE_W-1:0]  min_reserve,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [STATUS_W-1:0]   status,
	input logic [BYTE_W-1:0]     read_byte,
	input logic [OUT_POS_W-1:0]  stream_position,
	input logic [COUNT_W-1:0]    unread_count,
	input logic [COUNT_W-1:0]    history_count
);

	// A request in flight blocks the next one for the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while a request is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(read_byte)
			&& $stable(stream_position)))
		else $error("stalled result changed");

	a_byte_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (read_byte != '0)) |-> (status == STAT_OK))
		else $error("nonzero byte delivered with a failure status");

	a_counts_fit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((14'(unread_count) + 14'(history_count)) <= 14'(BUFFER_BYTES)))
		else $error("unread plus history exceeds the buffer size");

endmodule

bind byte_ring_buffer_with_rewind brb_checker u_brb_checker (.*);
